// ===== rtl/core/imuct_pkg.sv =====
// shared types, constants and the arctangent table of the tilt filter
`default_nettype none
package imuct_pkg;

  // field widths
  localparam int RAW_W      = 16;
  localparam int TIME_W     = 32;
  localparam int ANG_W      = 25;
  localparam int ALPHA_W    = 17;
  localparam int FDT_W      = 20;
  localparam int GAIN_W     = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN = 2'd2;

  // reset values of the registers
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd64225;
  localparam logic [FDT_W-1:0]   FDT_RST   = 20'd20000;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd8393;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  // datapath widths (sized for the widest angle format)
  localparam int X_W   = 40;
  localparam int Z_W   = 42;
  localparam int Y2_W  = 34;
  localparam int P_W   = 33;
  localparam int S_W   = 46;
  localparam int ACC_W = 32;
  localparam int MA_W  = 48;
  localparam int MB_W  = 18;
  localparam int PR_W  = 64;
  localparam int TAB_LEN = 24;

  // cordic gain in q16, applied to -ax
  localparam logic signed [MB_W-1:0] NEG_GAIN_Q16 = -18'sd107922;
  // 180 degrees in q32
  localparam logic signed [Z_W-1:0] Z_180 = 42'sd773094113280;

  localparam logic signed [ANG_W-1:0] OUT_MAX = 25'sd16777215;
  localparam logic signed [ANG_W-1:0] OUT_MIN = -25'sd16777216;

  // multiplier operations, in sequence order
  typedef enum logic [3:0] {
    OP_GAX = 4'd0,
    OP_GR  = 4'd1,
    OP_DLR = 4'd2,
    OP_DHR = 4'd3,
    OP_GP  = 4'd4,
    OP_DLP = 4'd5,
    OP_DHP = 4'd6,
    OP_BAR = 4'd7,
    OP_BBR = 4'd8,
    OP_BAP = 4'd9,
    OP_BBP = 4'd10
  } op_t;

  // atan(2^-i) in degrees, q32
  function automatic logic signed [Z_W-1:0] atan_q32(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    v = '0;
    case (idx)
      5'd0:  v = 42'sd193273528320;
      5'd1:  v = 42'sd114096026022;
      5'd2:  v = 42'sd60285206653;
      5'd3:  v = 42'sd30601712202;
      5'd4:  v = 42'sd15360239180;
      5'd5:  v = 42'sd7687607525;
      5'd6:  v = 42'sd3844741810;
      5'd7:  v = 42'sd1922488225;
      5'd8:  v = 42'sd961258780;
      5'd9:  v = 42'sd480631223;
      5'd10: v = 42'sd240315841;
      5'd11: v = 42'sd120157949;
      5'd12: v = 42'sd60078978;
      5'd13: v = 42'sd30039490;
      5'd14: v = 42'sd15019745;
      5'd15: v = 42'sd7509872;
      5'd16: v = 42'sd3754936;
      5'd17: v = 42'sd1877468;
      5'd18: v = 42'sd938734;
      5'd19: v = 42'sd469367;
      5'd20: v = 42'sd234684;
      5'd21: v = 42'sd117342;
      5'd22: v = 42'sd58671;
      5'd23: v = 42'sd29335;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/imuct_channels.sv =====
// handshake channel interfaces for samples, results and register writes
`default_nettype none
interface imuct_in_if;
  logic valid;
  logic ready;
  logic signed [imuct_pkg::RAW_W-1:0] accel_x;
  logic signed [imuct_pkg::RAW_W-1:0] accel_y;
  logic signed [imuct_pkg::RAW_W-1:0] accel_z;
  logic signed [imuct_pkg::RAW_W-1:0] gyro_x;
  logic signed [imuct_pkg::RAW_W-1:0] gyro_y;
  logic [imuct_pkg::TIME_W-1:0] time_us;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, time_us,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, time_us,
                output ready);
endinterface

interface imuct_out_if;
  logic valid;
  logic ready;
  logic signed [imuct_pkg::ANG_W-1:0] roll_angle;
  logic signed [imuct_pkg::ANG_W-1:0] pitch_angle;
  modport source (output valid, roll_angle, pitch_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface

interface imuct_cfg_if;
  logic valid;
  logic ready;
  logic [imuct_pkg::CFG_IDX_W-1:0]  index;
  logic [imuct_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/imu_complementary_tilt_filter_top.sv =====
// complementary roll/pitch filter: sequencer, shared multiplier and state
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | accel_x/y/z, gyro_x/y, time_us
//  out_ch   | out | valid/ready      | roll_angle, pitch_angle
//  cfg_ch   | in  | valid/ready (=1) | index, data
//
// one item runs seven multiplies, two cordic vectoring passes and four more multiplies,
// eleven through one shared multiplier with a multiply and an accumulate state each,
// then loads the output and returns to idle. in_ready is high only while idle. the
// output load waits while an older result is still unread; a loaded result waits while
// the next item is accepted. synchronous active-low reset clears estimates and the
// first-sample flag and restores the configuration registers to their reset values.
`default_nettype none
module imu_complementary_tilt_filter_top #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  imuct_in_if.sink    in_ch,
  imuct_out_if.source out_ch,
  imuct_cfg_if.sink   cfg_ch
);
  localparam int X_W  = imuct_pkg::X_W;
  localparam int Z_W  = imuct_pkg::Z_W;
  localparam int MA_W = imuct_pkg::MA_W;
  localparam int MB_W = imuct_pkg::MB_W;
  localparam int PR_W = imuct_pkg::PR_W;
  localparam int S_W  = imuct_pkg::S_W;
  localparam int ANG_W = imuct_pkg::ANG_W;
  localparam int ACC_W = imuct_pkg::ACC_W;
  localparam int G_SH = 40 - ANGLE_FRAC_BITS;
  localparam int Z_SH = 32 - ANGLE_FRAC_BITS;
  localparam logic signed [PR_W-1:0] G_RND = PR_W'(64'd1 << (39 - ANGLE_FRAC_BITS));
  localparam logic signed [Z_W-1:0]  Z_RND = Z_W'(64'd1 << (31 - ANGLE_FRAC_BITS));
  localparam logic signed [PR_W-1:0] B_RND = PR_W'(32768);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_VEC1 = 6'b001000,
    ST_VEC2 = 6'b010000,
    ST_DONE = 6'b100000
  } st_t;

  st_t state_r, state_nxt;
  imuct_pkg::op_t op_r, op_nxt;

  // configuration registers
  logic [imuct_pkg::ALPHA_W-1:0] alpha_r;
  logic [imuct_pkg::FDT_W-1:0]   first_dt_r;
  logic [imuct_pkg::GAIN_W-1:0]  gain_r;

  // filter state
  logic signed [ANG_W-1:0] roll_est_r, pitch_est_r;
  logic [imuct_pkg::TIME_W-1:0] last_time_r;
  logic have_last_r;

  // per-item working registers
  logic signed [imuct_pkg::RAW_W-1:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic [imuct_pkg::TIME_W-1:0] dt_r;
  logic signed [imuct_pkg::P_W-1:0]  p_r;
  logic signed [imuct_pkg::Y2_W-1:0] y2_r;
  logic signed [S_W-1:0]   s_roll_r, s_pitch_r;
  logic signed [ACC_W-1:0] acc_roll_r, acc_pitch_r;
  logic signed [PR_W-1:0]  acc_r, prod_r;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic signed [ANG_W-1:0] out_roll_r, out_pitch_r;

  logic in_acc, out_acc, cfg_acc, load_out;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MA_W+MB_W-1:0] prod_full;
  logic [imuct_pkg::ALPHA_W-1:0] a_eff, a_cmp;

  // cordic hookup
  logic cstart, cdone;
  logic signed [X_W-1:0] cx_in, cy_in, cmag;
  logic signed [Z_W-1:0] cz;
  logic signed [Z_W-1:0] z_rnd;
  logic signed [ACC_W-1:0] ang_q;

  // post-multiply arithmetic
  logic signed [PR_W-1:0] gsum, gdelta, bsum, bq;
  logic signed [S_W-1:0]  s_new;
  logic signed [ANG_W-1:0] bsat;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.roll_angle  = out_roll_r;
  assign out_ch.pitch_angle = out_pitch_r;

  // alpha above one acts as one
  assign a_eff = alpha_r[imuct_pkg::ALPHA_W-1] ? imuct_pkg::ALPHA_ONE : alpha_r;
  assign a_cmp = imuct_pkg::ALPHA_ONE - a_eff;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      imuct_pkg::OP_GAX: begin
        mul_a = MA_W'(ax_r);
        mul_b = imuct_pkg::NEG_GAIN_Q16;
      end
      imuct_pkg::OP_GR: begin
        mul_a = MA_W'(gx_r);
        mul_b = MB_W'(gain_r);
      end
      imuct_pkg::OP_GP: begin
        mul_a = MA_W'(gy_r);
        mul_b = MB_W'(gain_r);
      end
      imuct_pkg::OP_DLR, imuct_pkg::OP_DLP: begin
        mul_a = MA_W'(p_r);
        mul_b = MB_W'(dt_r[15:0]);
      end
      imuct_pkg::OP_DHR, imuct_pkg::OP_DHP: begin
        mul_a = MA_W'(p_r);
        mul_b = MB_W'(dt_r[31:16]);
      end
      imuct_pkg::OP_BAR: begin
        mul_a = MA_W'(s_roll_r);
        mul_b = MB_W'(a_eff);
      end
      imuct_pkg::OP_BBR: begin
        mul_a = MA_W'(acc_roll_r);
        mul_b = MB_W'(a_cmp);
      end
      imuct_pkg::OP_BAP: begin
        mul_a = MA_W'(s_pitch_r);
        mul_b = MB_W'(a_eff);
      end
      imuct_pkg::OP_BBP: begin
        mul_a = MA_W'(acc_pitch_r);
        mul_b = MB_W'(a_cmp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // gyro increment: high partial product joins the low one, then round-shift
  assign gsum   = acc_r + (prod_r <<< 16);
  assign gdelta = gsum >>> G_SH;
  always_comb begin
    if (op_r == imuct_pkg::OP_DHR) begin
      s_new = S_W'(roll_est_r) + gdelta[S_W-1:0];
    end else begin
      s_new = S_W'(pitch_est_r) + gdelta[S_W-1:0];
    end
  end

  // blend: second term joins the first, rounded, then saturated
  assign bsum = acc_r + prod_r;
  assign bq   = bsum >>> 16;
  always_comb begin
    if (bq > PR_W'(imuct_pkg::OUT_MAX)) begin
      bsat = imuct_pkg::OUT_MAX;
    end else if (bq < PR_W'(imuct_pkg::OUT_MIN)) begin
      bsat = imuct_pkg::OUT_MIN;
    end else begin
      bsat = bq[ANG_W-1:0];
    end
  end

  // q32 cordic angle to output format, rounded half up
  assign z_rnd = cz + Z_RND;
  assign ang_q = ACC_W'(z_rnd >>> Z_SH);

  // cordic start: roll pass after the gyro terms, pitch pass after roll
  always_comb begin
    cstart = 1'b0;
    cx_in  = X_W'(az_r) <<< 16;
    cy_in  = X_W'(ay_r) <<< 16;
    if (state_r == ST_ACC && op_r == imuct_pkg::OP_DHP) begin
      cstart = 1'b1;
    end else if (state_r == ST_VEC1 && cdone) begin
      cstart = 1'b1;
      cx_in  = cmag;
      cy_in  = X_W'(y2_r);
    end
  end

  imuct_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cstart),
    .x_in   (cx_in),
    .y_in   (cy_in),
    .done   (cdone),
    .z_out  (cz),
    .mag_out(cmag)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt    = imuct_pkg::OP_GAX;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        if (op_r == imuct_pkg::OP_DHP) begin
          state_nxt = ST_VEC1;
        end else if (op_r == imuct_pkg::OP_BBP) begin
          state_nxt = ST_DONE;
        end else begin
          op_nxt    = imuct_pkg::op_t'(op_r + 4'd1);
          state_nxt = ST_MUL;
        end
      end
      ST_VEC1: begin
        if (cdone) begin
          state_nxt = ST_VEC2;
        end
      end
      ST_VEC2: begin
        if (cdone) begin
          op_nxt    = imuct_pkg::OP_BAR;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid holds until taken, reloads on completion
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= imuct_pkg::OP_GAX;
      out_valid_r <= 1'b0;
      alpha_r     <= imuct_pkg::ALPHA_RST;
      first_dt_r  <= imuct_pkg::FDT_RST;
      gain_r      <= imuct_pkg::GAIN_RST;
      roll_est_r  <= '0;
      pitch_est_r <= '0;
      last_time_r <= '0;
      have_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc) begin
        case (cfg_ch.index)
          imuct_pkg::REG_ALPHA:     alpha_r    <= cfg_ch.data[imuct_pkg::ALPHA_W-1:0];
          imuct_pkg::REG_FIRST_DT:  first_dt_r <= cfg_ch.data;
          imuct_pkg::REG_GYRO_GAIN: gain_r     <= cfg_ch.data[imuct_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        last_time_r <= in_ch.time_us;
        have_last_r <= 1'b1;
      end
      if (state_r == ST_ACC && op_r == imuct_pkg::OP_BBR) begin
        roll_est_r <= bsat;
      end
      if (state_r == ST_ACC && op_r == imuct_pkg::OP_BBP) begin
        pitch_est_r <= bsat;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r <= in_ch.accel_x;
      ay_r <= in_ch.accel_y;
      az_r <= in_ch.accel_z;
      gx_r <= in_ch.gyro_x;
      gy_r <= in_ch.gyro_y;
      dt_r <= have_last_r ? (in_ch.time_us - last_time_r)
                          : imuct_pkg::TIME_W'(first_dt_r);
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_full[PR_W-1:0];
    end
    if (state_r == ST_ACC) begin
      case (op_r)
        imuct_pkg::OP_GAX: y2_r <= prod_r[imuct_pkg::Y2_W-1:0];
        imuct_pkg::OP_GR, imuct_pkg::OP_GP: p_r <= prod_r[imuct_pkg::P_W-1:0];
        imuct_pkg::OP_DLR, imuct_pkg::OP_DLP: acc_r <= prod_r + G_RND;
        imuct_pkg::OP_DHR: s_roll_r <= s_new;
        imuct_pkg::OP_DHP: s_pitch_r <= s_new;
        imuct_pkg::OP_BAR, imuct_pkg::OP_BAP: acc_r <= prod_r + B_RND;
        default: ;
      endcase
    end
    if (state_r == ST_VEC1 && cdone) begin
      acc_roll_r <= ang_q;
    end
    if (state_r == ST_VEC2 && cdone) begin
      acc_pitch_r <= ang_q;
    end
    if (load_out) begin
      out_roll_r  <= roll_est_r;
      out_pitch_r <= pitch_est_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/imuct_cordic.sv =====
// iterative cordic vectoring unit: atan2 in q32 degrees and scaled magnitude
`default_nettype none
module imuct_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic signed [imuct_pkg::X_W-1:0] x_in,
  input  wire logic signed [imuct_pkg::X_W-1:0] y_in,
  output logic done,
  output logic signed [imuct_pkg::Z_W-1:0] z_out,
  output logic signed [imuct_pkg::X_W-1:0] mag_out
);
  localparam int IT_W = $clog2(CORDIC_STEPS);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_INIT = 4'b0010,
    C_ITER = 4'b0100,
    C_DONE = 4'b1000
  } cst_t;

  cst_t state_r, state_nxt;
  logic signed [imuct_pkg::X_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [imuct_pkg::Z_W-1:0] z_r, z_nxt;
  logic [IT_W-1:0] it_r, it_nxt;
  logic signed [imuct_pkg::X_W-1:0] xs, ys;
  logic signed [imuct_pkg::Z_W-1:0] tab;

  // shifted operands and table angle for the current step
  assign xs  = x_r >>> it_r;
  assign ys  = y_r >>> it_r;
  assign tab = imuct_pkg::atan_q32(5'(it_r));

  // sequencer and rotation datapath
  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    it_nxt = it_r;
    case (state_r)
      C_IDLE, C_DONE: begin
        if (start) begin
          x_nxt = x_in;
          y_nxt = y_in;
          z_nxt = '0;
          state_nxt = C_INIT;
        end else begin
          state_nxt = C_IDLE;
        end
      end
      C_INIT: begin
        it_nxt = '0;
        if (x_r == '0 && y_r == '0) begin
          state_nxt = C_DONE;
        end else begin
          // left half plane: pre-rotate by 180 degrees
          if (x_r < 0) begin
            z_nxt = (y_r >= 0) ? imuct_pkg::Z_180 : -imuct_pkg::Z_180;
            x_nxt = -x_r;
            y_nxt = -y_r;
          end
          state_nxt = C_ITER;
        end
      end
      C_ITER: begin
        if (y_r >= 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + tab;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - tab;
        end
        it_nxt = it_r + 1'b1;
        if (it_r == IT_LAST) begin
          state_nxt = C_DONE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    it_r <= it_nxt;
  end

  assign done    = (state_r == C_DONE);
  assign z_out   = z_r;
  assign mag_out = x_r;

endmodule
`default_nettype wire

// ===== rtl/core/imuct_checker.sv =====
// port-level checker for the tilt filter, bound to the top level
`default_nettype none
module imuct_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [imuct_pkg::ANG_W-1:0] out_roll,
  input wire logic [imuct_pkg::ANG_W-1:0] out_pitch,
  input wire logic cfg_ready
);
  // an accepted item drops input ready
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted item");

  // no result appears the cycle after an item enters an empty output
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared without computation time");

  // register port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

  // a stalled result keeps valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_roll) && $stable(out_pitch)))
    else $error("stalled result changed");

endmodule

bind imu_complementary_tilt_filter_top imuct_checker u_imuct_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_roll (out_ch.roll_angle),
  .out_pitch(out_ch.pitch_angle),
  .cfg_ready(cfg_ch.ready)
);
`default_nettype wire

// ===== test/imuct_tilt_checker.sv =====
// checker: predicts filtered roll and pitch per sample and compares results
`default_nettype none
module imuct_tilt_checker (
  input wire logic clk,
  input wire logic rst_n,
  imuct_in_if.sink  in_mon,
  imuct_out_if.sink out_mon,
  imuct_cfg_if.sink cfg_mon,
  output int        fail_count,
  output int        pending_count
);
  typedef struct packed {
    logic signed [imuct_pkg::ANG_W-1:0] roll;
    logic signed [imuct_pkg::ANG_W-1:0] pitch;
  } tilt_t;

  tilt_t expected_tilt[$];

  logic [imuct_pkg::ALPHA_W-1:0] alpha_reg;
  logic [imuct_pkg::FDT_W-1:0]   first_dt_reg;
  logic [imuct_pkg::GAIN_W-1:0]  gain_reg;
  longint                        roll_state;
  longint                        pitch_state;
  logic [imuct_pkg::TIME_W-1:0]  prev_time;
  logic                          seen_sample;

  // floor division by 2^n
  function automatic longint fshr(input longint v, input int n);
    return v >>> n;
  endfunction

  // cordic vectoring, angle in q32 degrees
  function automatic longint cordic_atan2(input longint y0, input longint x0,
                                          output longint mag);
    longint x, y, z, xs, ys;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? 64'sd773094113280 : -64'sd773094113280;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(imuct_pkg::atan_q32(i[4:0]));
      end else begin
        x -= ys; y += xs; z -= longint'(imuct_pkg::atan_q32(i[4:0]));
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint gyro_incr(input longint rate, input longint dt);
    longint p;
    p = rate * dt * longint'(gain_reg);
    return fshr(p + (64'sd1 <<< 23), 24);
  endfunction

  function automatic longint blend_angle(input longint est, input longint d,
                                         input longint acc);
    longint a, v;
    a = (alpha_reg > imuct_pkg::ALPHA_ONE) ? 65536 : longint'(alpha_reg);
    v = fshr(a * (est + d) + (65536 - a) * acc + 32768, 16);
    if (v > 16777215) v = 16777215;
    if (v < -16777216) v = -16777216;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_count = expected_tilt.size();

  always @(posedge clk) begin
    longint ax, ay, az, mag, dummy, acc_r, acc_p, dt;
    logic [imuct_pkg::TIME_W-1:0] dt_u;
    tilt_t t, w;
    if (!rst_n) begin
      alpha_reg <= imuct_pkg::ALPHA_RST;
      first_dt_reg <= imuct_pkg::FDT_RST;
      gain_reg <= imuct_pkg::GAIN_RST;
      roll_state = 0;
      pitch_state = 0;
      prev_time = '0;
      seen_sample = 1'b0;
      fail_count = 0;
      expected_tilt.delete();
    end else begin
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          imuct_pkg::REG_ALPHA:
            alpha_reg <= cfg_mon.data[imuct_pkg::ALPHA_W-1:0];
          imuct_pkg::REG_FIRST_DT:
            first_dt_reg <= cfg_mon.data[imuct_pkg::FDT_W-1:0];
          imuct_pkg::REG_GYRO_GAIN:
            gain_reg <= cfg_mon.data[imuct_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      // predict one result per accepted sample
      if (in_mon.valid && in_mon.ready) begin
        // time step wraps at the timestamp width
        dt_u = in_mon.time_us - prev_time;
        dt = seen_sample ? longint'(dt_u) : longint'(first_dt_reg);
        prev_time = in_mon.time_us;
        seen_sample = 1'b1;
        ax = in_mon.accel_x;
        ay = in_mon.accel_y;
        az = in_mon.accel_z;
        acc_r = fshr(cordic_atan2(ay * 65536, az * 65536, mag) + (64'sd1 <<< 15), 16);
        acc_p = fshr(cordic_atan2(-ax * 107922, mag, dummy) + (64'sd1 <<< 15), 16);
        roll_state = blend_angle(roll_state, gyro_incr(in_mon.gyro_x, dt), acc_r);
        pitch_state = blend_angle(pitch_state, gyro_incr(in_mon.gyro_y, dt), acc_p);
        t.roll = roll_state[imuct_pkg::ANG_W-1:0];
        t.pitch = pitch_state[imuct_pkg::ANG_W-1:0];
        expected_tilt.push_back(t);
      end
      // compare results
      if (out_mon.valid && out_mon.ready) begin
        if (expected_tilt.size() == 0) begin
          report_mismatch("unexpected result item, roll", out_mon.roll_angle, 0);
        end else begin
          w = expected_tilt.pop_front();
          if (out_mon.roll_angle !== w.roll)
            report_mismatch("roll", out_mon.roll_angle, w.roll);
          if (out_mon.pitch_angle !== w.pitch)
            report_mismatch("pitch", out_mon.pitch_angle, w.pitch);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/tb_imu_complementary_tilt_filter_top.sv =====
// testbench top: sample stimulus, register phases, stalls and verdict
`default_nettype none
module tb_imu_complementary_tilt_filter_top;
  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  logic [imuct_pkg::TIME_W-1:0] now_us;

  imuct_in_if  in_ch ();
  imuct_out_if out_ch ();
  imuct_cfg_if cfg_ch ();

  imu_complementary_tilt_filter_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  imuct_tilt_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver stalls: pattern mode changes every so often
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ($urandom_range(0, 99) < 97) ? 1'b1 : 1'b0;
      endcase
    end
  end

  // valid stays high after the write; the caller drops it when done
  task automatic write_reg(input logic [imuct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [imuct_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // valid stays high after the item; the caller drops it before a gap
  task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
                             input logic [15:0] gx, input logic [15:0] gy,
                             input logic [imuct_pkg::TIME_W-1:0] ts);
    in_ch.valid <= 1'b1;
    in_ch.accel_x <= ax;
    in_ch.accel_y <= ay;
    in_ch.accel_z <= az;
    in_ch.gyro_x <= gx;
    in_ch.gyro_y <= gy;
    in_ch.time_us <= ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // random sample burst with gaps
  task automatic random_samples(input int count);
    int left, burst;
    logic [15:0] g;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        case ($urandom_range(0, 9))
          0: now_us = $urandom;
          1: now_us = now_us - $urandom_range(1, 1000);
          default: now_us = now_us + $urandom_range(1, 50000);
        endcase
        if ($urandom_range(0, 3) == 0) g = pick_raw();
        else g = 16'($urandom_range(0, 4000)) - 16'd2000;
        send_sample(pick_raw(), pick_raw(), pick_raw(), g,
                    ($urandom_range(0, 3) == 0) ? pick_raw() : 16'($urandom_range(0, 600)) - 16'd300,
                    now_us);
        left--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 150)) @(negedge clk);
      end
    end
  endtask

  initial begin
    logic [16:0] alpha_set [5];
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
    in_ch.gyro_x = '0; in_ch.gyro_y = '0; in_ch.time_us = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = imuct_pkg::REG_ALPHA; cfg_ch.data = '0;
    rst_n = 1'b0;
    now_us = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: first sample, extremes, zero vector, negative x, wrap
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 32'd1000);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd21000);
    send_sample(16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd41000);
    send_sample(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 32'd61000);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 32'd81000);
    send_sample(16'h0000, 16'h0100, 16'hff00, 16'h0064, 16'hff9c, 32'd101000);
    send_sample(16'h0000, 16'hff00, 16'hff00, 16'h0000, 16'h0000, 32'd121000);
    send_sample(16'hffff, 16'h0000, 16'h4000, 16'h0001, 16'hffff, 32'hfffffff0);
    send_sample(16'h0001, 16'h0001, 16'h0001, 16'h7fff, 16'h7fff, 32'h00000010);
    send_sample(16'h5555, 16'haaaa, 16'h5555, 16'h8000, 16'h8000, 32'h00000005);
    send_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h0000, 16'h0000, 32'h00000006);
    wait_drained();

    // register phases, extremes among them
    alpha_set = '{17'd65536, 17'd0, 17'h1ffff, 17'd32768, 17'd64225};
    for (int p = 0; p < 5; p++) begin
      write_reg(imuct_pkg::REG_ALPHA, 20'(alpha_set[p]));
      write_reg(imuct_pkg::REG_FIRST_DT,
                (p == 2) ? 20'hfffff : 20'($urandom_range(0, 1048575)));
      write_reg(imuct_pkg::REG_GYRO_GAIN, (p == 1) ? 20'hffff : (p == 3) ? 20'd0 :
                20'($urandom_range(0, 65535)));
      cfg_ch.valid <= 1'b0;
      random_samples(360);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
